[rtl/rbsi_pkg.sv]
package rbsi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // divider: one overflow step plus 33 quotient bits, then a saturation stage
  localparam int QUO_W   = 34;
  localparam int DIV_LAT = QUO_W + 1;

  localparam int ADDR_W = 5;
  localparam int NUM_AXES = 3;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] near_in;
    logic signed [31:0] far_in;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] near_out;
    logic signed [31:0] far_out;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] near_v;
    logic signed [31:0] far_v;
  } span_t;

endpackage

[rtl/rbsi_div.sv]
module rbsi_div import rbsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [32:0]        num_mag,
  input  logic [31:0]        den_mag,
  input  logic               neg,
  output logic signed [31:0] quo
);

  localparam int NW = 33 + FRAC_BITS;

  logic [NW-1:0]    rem_r [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W];
  logic [31:0]      den_r [QUO_W];
  logic             neg_r [QUO_W];

  genvar s;
  for (s = 0; s < QUO_W; s++) begin : g_step
    localparam int SH = QUO_W - 1 - s;
    logic [NW-1:0]    rem_i;
    logic [QUO_W-1:0] q_i;
    logic [31:0]      den_i;
    logic             neg_i;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_i = {num_mag, {FRAC_BITS{1'b0}}};
      assign q_i   = '0;
      assign den_i = den_mag;
      assign neg_i = neg;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign q_i   = q_r[s-1];
      assign den_i = den_r[s-1];
      assign neg_i = neg_r[s-1];
    end

    // first step flags a quotient of 2^33 or more; a zero divisor always lands here
    assign ge = (rem_i >> SH) >= NW'(den_i);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? rem_i - (NW'(den_i) << SH) : rem_i;
        q_r[s]   <= {q_i[QUO_W-2:0], ge};
        den_r[s] <= den_i;
        neg_r[s] <= neg_i;
      end
    end
  end

  logic        ovf;
  logic [32:0] q_mag;
  logic [31:0] q_neg;
  logic signed [31:0] quo_next;

  assign ovf   = q_r[QUO_W-1][QUO_W-1];
  assign q_mag = q_r[QUO_W-1][32:0];
  assign q_neg = 32'(~q_mag + 33'd1);

  always_comb begin
    if (neg_r[QUO_W-1]) begin
      if (ovf || q_mag > 33'h0_8000_0000) quo_next = 32'sh8000_0000;
      else quo_next = $signed(q_neg);
    end else begin
      if (ovf || q_mag[32:31] != 2'b00) quo_next = 32'sh7FFF_FFFF;
      else quo_next = $signed(q_mag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= quo_next;
    end
  end

endmodule

[rtl/ray_box_slab_intersect.sv]
// Throughput: one item per cycle; the six plane distances come from
// pipelined long dividers, one quotient bit per stage, then saturation
// (35 stages each). The whole pipeline holds while a finished result
// waits on out_ready. Reset (rst, synchronous, active high) clears the
// valid bits and the six box registers to zero.
module ray_box_slab_intersect import rbsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration
  logic [31:0] bmin [NUM_AXES];
  logic [31:0] bmax [NUM_AXES];
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        bmin[a] <= '0;
        bmax[a] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_MIN_X: bmin[0] <= pwdata;
        REG_MIN_Y: bmin[1] <= pwdata;
        REG_MIN_Z: bmin[2] <= pwdata;
        REG_MAX_X: bmax[0] <= pwdata;
        REG_MAX_Y: bmax[1] <= pwdata;
        REG_MAX_Z: bmax[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MIN_X: prdata = bmin[0];
      REG_MIN_Y: prdata = bmin[1];
      REG_MIN_Z: prdata = bmin[2];
      REG_MAX_X: prdata = bmax[0];
      REG_MAX_Y: prdata = bmax[1];
      REG_MAX_Z: prdata = bmax[2];
      default:   prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: numerator and divisor magnitudes
  logic [31:0] org [NUM_AXES];
  logic [31:0] dir [NUM_AXES];
  logic [32:0] num_lo [NUM_AXES];
  logic [32:0] num_hi [NUM_AXES];

  assign org[0] = in_data.origin_x;
  assign org[1] = in_data.origin_y;
  assign org[2] = in_data.origin_z;
  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  logic        v0;
  logic [32:0] mag_lo_r [NUM_AXES];
  logic [32:0] mag_hi_r [NUM_AXES];
  logic [31:0] mag_d_r  [NUM_AXES];
  logic        neg_lo_r [NUM_AXES];
  logic        neg_hi_r [NUM_AXES];
  span_t       span0;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      num_lo[a] = {bmin[a][31], bmin[a]} - {org[a][31], org[a]};
      num_hi[a] = {bmax[a][31], bmax[a]} - {org[a][31], org[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        mag_lo_r[a] <= num_lo[a][32] ? ~num_lo[a] + 33'd1 : num_lo[a];
        mag_hi_r[a] <= num_hi[a][32] ? ~num_hi[a] + 33'd1 : num_hi[a];
        mag_d_r[a]  <= dir[a][31] ? ~dir[a] + 32'd1 : dir[a];
        neg_lo_r[a] <= num_lo[a][32] ^ dir[a][31];
        neg_hi_r[a] <= num_hi[a][32] ^ dir[a][31];
      end
      span0.near_v <= in_data.near_in;
      span0.far_v  <= in_data.far_in;
    end
  end

  // dividers
  logic signed [31:0] t_a [NUM_AXES];
  logic signed [31:0] t_b [NUM_AXES];

  genvar g;
  for (g = 0; g < NUM_AXES; g++) begin : g_axis
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk     (clk),
      .en      (en),
      .num_mag (mag_lo_r[g]),
      .den_mag (mag_d_r[g]),
      .neg     (neg_lo_r[g]),
      .quo     (t_a[g])
    );
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk     (clk),
      .en      (en),
      .num_mag (mag_hi_r[g]),
      .den_mag (mag_d_r[g]),
      .neg     (neg_hi_r[g]),
      .quo     (t_b[g])
    );
  end

  // side band delayed alongside the dividers
  logic  vd   [DIV_LAT];
  span_t spd  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v0;
      for (int i = 1; i < DIV_LAT; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spd[0] <= span0;
      for (int i = 1; i < DIV_LAT; i++) spd[i] <= spd[i-1];
    end
  end

  // sort each slab
  logic               v_sort;
  logic signed [31:0] lo_r [NUM_AXES];
  logic signed [31:0] hi_r [NUM_AXES];
  span_t              sp_sort;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sort <= 1'b0;
    end else if (en) begin
      v_sort <= vd[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lo_r[a] <= (t_a[a] > t_b[a]) ? t_b[a] : t_a[a];
        hi_r[a] <= (t_a[a] > t_b[a]) ? t_a[a] : t_b[a];
      end
      sp_sort <= spd[DIV_LAT-1];
    end
  end

  // x against y
  logic               v_xy;
  logic               hit_xy;
  logic signed [31:0] t0_xy, t1_xy, lz_xy, hz_xy;
  span_t              sp_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_xy <= 1'b0;
    end else if (en) begin
      v_xy <= v_sort;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_xy <= !(lo_r[0] > hi_r[1] || lo_r[1] > hi_r[0]);
      t0_xy  <= (lo_r[1] > lo_r[0]) ? lo_r[1] : lo_r[0];
      t1_xy  <= (hi_r[1] < hi_r[0]) ? hi_r[1] : hi_r[0];
      lz_xy  <= lo_r[2];
      hz_xy  <= hi_r[2];
      sp_xy  <= sp_sort;
    end
  end

  // z and the running span
  logic               hit_f;
  logic signed [31:0] t0_f, t1_f;
  out_item_t          out_next;

  always_comb begin
    hit_f = hit_xy && !(t0_xy > hz_xy || lz_xy > t1_xy);
    t0_f  = (lz_xy > t0_xy) ? lz_xy : t0_xy;
    t1_f  = (hz_xy < t1_xy) ? hz_xy : t1_xy;
    out_next.hit      = hit_f;
    out_next.near_out = (hit_f && t0_f < sp_xy.near_v) ? t0_f : sp_xy.near_v;
    out_next.far_out  = (hit_f && t1_f > sp_xy.far_v) ? t1_f : sp_xy.far_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_xy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

[rtl/rbsi_chk.sv]
module rbsi_chk import rbsi_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input refused with output free");

  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline held");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind ray_box_slab_intersect rbsi_chk u_rbsi_chk (.*);

[test/slab_checker.sv]
module slab_checker import rbsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic      pready,
  output int        fail_count,
  output int        pending,
  output int        hit_count,
  output int        result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;

  logic signed [31:0] box_lo [NUM_AXES];
  logic signed [31:0] box_hi [NUM_AXES];
  out_item_t expected_hits[$];

  function automatic logic signed [63:0] plane_dist(logic signed [63:0] num,
                                                    logic signed [63:0] den);
    logic [63:0] mag_n;
    logic [63:0] mag_d;
    logic [63:0] q;
    mag_n = num < 0 ? -num : num;
    mag_d = den < 0 ? -den : den;
    if (mag_d == 0) return num < 0 ? -64'sd2147483648 : 64'sd2147483647;
    q = (mag_n << FB) / mag_d;
    if ((num < 0) != (den < 0)) begin
      if (q > 64'h8000_0000) return -64'sd2147483648;
      return -$signed(q);
    end
    if (q > 64'h7FFF_FFFF) return 64'sd2147483647;
    return $signed(q);
  endfunction

  function automatic out_item_t box_test(in_item_t r);
    logic signed [31:0] org [NUM_AXES];
    logic signed [31:0] dir [NUM_AXES];
    logic signed [63:0] a, b, t, t0, t1, nr, fr;
    logic h;
    out_item_t o;
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dir[0] = r.dir_x;    dir[1] = r.dir_y;    dir[2] = r.dir_z;
    h = 1'b1;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      if (h) begin
        a = plane_dist(64'(box_lo[ax]) - 64'(org[ax]), 64'(dir[ax]));
        b = plane_dist(64'(box_hi[ax]) - 64'(org[ax]), 64'(dir[ax]));
        if (a > b) begin
          t = a; a = b; b = t;
        end
        if (ax == 0) begin
          t0 = a; t1 = b;
        end else if (t0 > b || a > t1) begin
          h = 1'b0;
        end else begin
          if (a > t0) t0 = a;
          if (b < t1) t1 = b;
        end
      end
    end
    nr = r.near_in;
    fr = r.far_in;
    if (h) begin
      if (t0 < nr) nr = t0;
      if (t1 > fr) fr = t1;
    end
    o.hit = h;
    o.near_out = nr[31:0];
    o.far_out = fr[31:0];
    return o;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
      fail_count <= 0;
      hit_count <= 0;
      result_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_hits.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_hits.pop_front();
          if (e.hit) hit_count <= hit_count + 1;
          if (out_data.hit !== e.hit || out_data.near_out !== e.near_out ||
              out_data.far_out !== e.far_out) begin
            if (fail_count < 10)
              $display("mismatch: exp hit=%0b near=%h far=%h got hit=%0b near=%h far=%h",
                       e.hit, e.near_out, e.far_out,
                       out_data.hit, out_data.near_out, out_data.far_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      // box registers are only written while idle, so predicting here is safe
      if (in_valid && in_ready)
        expected_hits.insert(expected_hits.size(), box_test(in_data));
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MIN_X: box_lo[0] <= pwdata;
          REG_MIN_Y: box_lo[1] <= pwdata;
          REG_MIN_Z: box_lo[2] <= pwdata;
          REG_MAX_X: box_hi[0] <= pwdata;
          REG_MAX_Y: box_hi[1] <= pwdata;
          REG_MAX_Z: box_hi[2] <= pwdata;
          default: ;
        endcase
      end
    end
  end
endmodule

[test/ray_box_slab_intersect_tb.sv]
module ray_box_slab_intersect_tb import rbsi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 39;
  localparam int WATCHDOG = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int fail_count, pending, hit_count, result_count;
  int idle_cycles = 0;
  int sent = 0;
  bit quiet_tail = 0;
  bit hold_sink = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ray_box_slab_intersect u_dut (.*);

  slab_checker u_chk (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sink side: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // back-to-back writes go straight from access to the next setup
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
  endtask

  task automatic load_box(logic [31:0] v [6]);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    for (int i = 0; i < 6; i++) reg_write(reg_idx_t'(i), v[i]);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // valid stays up after an item unless a gap follows
  task automatic send_ray(in_item_t r);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0;
      default: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
    endcase
  endfunction

  function automatic in_item_t rnd_ray();
    in_item_t r;
    r.origin_x = rnd_q(); r.origin_y = rnd_q(); r.origin_z = rnd_q();
    r.dir_x = rnd_q(); r.dir_y = rnd_q(); r.dir_z = rnd_q();
    r.near_in = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : rnd_q();
    r.far_in = $urandom_range(0, 1) ? 32'sh8000_0000 : rnd_q();
    return r;
  endfunction

  // ray from outside aimed through the box centre region, so most items hit
  function automatic in_item_t aimed_ray();
    in_item_t r;
    r.origin_x = -32'sh0004_0000 + $signed($urandom_range(0, 32'h0002_0000));
    r.origin_y = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    r.origin_z = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    r.dir_x = $urandom_range(1, 32'h0002_0000);
    r.dir_y = $signed($urandom_range(0, 32'h0000_4000)) - 32'sh2000;
    r.dir_z = $signed($urandom_range(0, 32'h0000_4000)) - 32'sh2000;
    r.near_in = 32'sh7FFF_FFFF;
    r.far_in = 32'sh8000_0000;
    return r;
  endfunction

  initial begin
    logic [31:0] unit_box [6];
    logic [31:0] wide_box [6];
    logic [31:0] flip_box [6];
    logic [31:0] rand_box [6];
    in_item_t r;
    unit_box = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                 32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    wide_box = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    flip_box = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero box from reset: zero directions, touching at the origin
    send_ray('0);
    r = '0; r.origin_x = 32'sh0001_0000; send_ray(r);
    load_box(unit_box);
    r = aimed_ray(); send_ray(r);
    r = '0; r.origin_x = -32'sh0002_0000; r.dir_x = 32'sh0001_0000;
    r.near_in = 32'sh7FFF_FFFF; r.far_in = 32'sh8000_0000; send_ray(r);
    // grazing: slab y touches exactly at the face
    r.origin_y = 32'sh0001_0000; r.dir_y = 0; send_ray(r);
    r.origin_y = 32'sh0001_0001; send_ray(r);
    // misses on y and on z
    r = '0; r.origin_x = -32'sh0002_0000; r.dir_x = 32'sh0001_0000;
    r.origin_y = 32'sh0005_0000; send_ray(r);
    r.origin_y = 0; r.origin_z = 32'sh0005_0000; send_ray(r);
    // saturating quotients: tiny directions, extreme origins
    r = '0; r.dir_x = 1; r.dir_y = -1; r.dir_z = 32'sh8000_0000;
    r.origin_x = 32'sh8000_0000; r.origin_y = 32'sh7FFF_FFFF; send_ray(r);
    r = '1; send_ray(r);
    r = '0; r.dir_x = 32'sh7FFF_FFFF; r.dir_y = 32'sh7FFF_FFFF; r.dir_z = 32'sh7FFF_FFFF;
    send_ray(r);
    load_box(wide_box);
    r = '0; r.origin_x = 32'sh8000_0000; r.dir_x = 1; send_ray(r);
    r = '0; r.origin_z = 32'sh7FFF_FFFF; r.dir_z = -1; r.dir_y = 32'sh8000_0000; send_ray(r);
    r = '1; r.origin_y = 32'sh8000_0000; send_ray(r);
    load_box(flip_box);
    r = aimed_ray(); send_ray(r);
    r = '0; r.origin_x = -32'sh0002_0000; r.dir_x = 32'sh0001_0000; send_ray(r);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_box(unit_box);
        1: load_box(wide_box);
        default: begin
          for (int i = 0; i < 6; i++) rand_box[i] = rnd_q();
          load_box(rand_box);
        end
      endcase
      if (ph == 2) hold_sink = 1;
      if (ph == 4) quiet_tail = 1;
      for (int k = 0; k < 107; k++) begin
        if ($urandom_range(0, 9) < 6) send_ray(aimed_ray());
        else send_ray(rnd_ray());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d rays over several box settings, %0d results checked, %0d hits",
             sent, result_count, hit_count);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
